// ===== rtl/core/ilws_pkg.sv =====
// Package with the function and status codes and the token control type of the list.
`timescale 1ns / 1ps

package ilws_pkg;

   localparam logic [2:0] FUNC_APPEND = 3'd0;
   localparam logic [2:0] FUNC_CLEAR  = 3'd1;
   localparam logic [2:0] FUNC_GET    = 3'd2;
   localparam logic [2:0] FUNC_SET    = 3'd3;
   localparam logic [2:0] FUNC_FIND   = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 4;
   localparam int FINDEX_W = 4;
   localparam int UCOUNT_W = 5;

   typedef struct packed {
      logic       valid;
      logic       done;
      logic [2:0] func;
   } token_ctl_type;

endpackage

// ===== rtl/core/ilws_cell.sv =====
// One cell of the list chain: holds one entry and serves the token passing through it.
`timescale 1ns / 1ps

module ilws_cell #(
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ilws_pkg::token_ctl_type       ctl_in,
   input  logic [ilws_pkg::DATA_W-1:0]   key_in,
   input  logic [ilws_pkg::DATA_W-1:0]   rdata_in,
   input  logic [CW-1:0]                 hidx_in,
   input  logic [CW-1:0]                 target,
   input  logic [CW-1:0]                 limit,
   output ilws_pkg::token_ctl_type       ctl_out,
   output logic [ilws_pkg::DATA_W-1:0]   key_out,
   output logic [ilws_pkg::DATA_W-1:0]   rdata_out,
   output logic [CW-1:0]                 hidx_out
);

   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

   logic [ilws_pkg::DATA_W-1:0] entry_ff;
   logic [ilws_pkg::DATA_W-1:0] entry_in;
   ilws_pkg::token_ctl_type     ctl_ff;
   ilws_pkg::token_ctl_type     ctl_in_next;
   logic [ilws_pkg::DATA_W-1:0] key_ff;
   logic [ilws_pkg::DATA_W-1:0] rdata_ff;
   logic [ilws_pkg::DATA_W-1:0] rdata_in_next;
   logic [CW-1:0]               hidx_ff;
   logic [CW-1:0]               hidx_in_next;
   logic                        is_target;
   logic                        hit;
   logic                        wr;

   assign is_target = (target == MY_INDEX);

   always_comb begin
      hit           = 1'b0;
      wr            = 1'b0;
      rdata_in_next = rdata_in;
      hidx_in_next  = hidx_in;
      if (ctl_in.valid && !ctl_in.done) begin
         case (ctl_in.func)
            ilws_pkg::FUNC_APPEND: begin
               if (is_target) begin
                  hit = 1'b1;
                  wr  = 1'b1;
               end
            end
            ilws_pkg::FUNC_GET: begin
               if (is_target) begin
                  hit           = 1'b1;
                  rdata_in_next = entry_ff;
               end
            end
            ilws_pkg::FUNC_SET: begin
               if (is_target) begin
                  hit           = 1'b1;
                  wr            = 1'b1;
                  rdata_in_next = entry_ff;
               end
            end
            ilws_pkg::FUNC_FIND: begin
               if ((MY_INDEX < limit) && (entry_ff == key_in)) begin
                  hit          = 1'b1;
                  hidx_in_next = MY_INDEX;
               end
            end
            default: ;
         endcase
      end
      entry_in          = wr ? key_in : entry_ff;
      ctl_in_next       = ctl_in;
      ctl_in_next.done  = ctl_in.done | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      key_ff   <= key_in;
      rdata_ff <= rdata_in_next;
      hidx_ff  <= hidx_in_next;
   end

   assign ctl_out   = ctl_ff;
   assign key_out   = key_ff;
   assign rdata_out = rdata_ff;
   assign hidx_out  = hidx_ff;

endmodule

// ===== rtl/core/indexed_list_with_search_top.sv =====
// Top level of the fixed-capacity list with linear search.
`timescale 1ns / 1ps

// The list keeps CAPACITY signed words in a chain of cells, one entry per cell, and a count
// of entries in use. Append, get, set and find send a token down the chain one cell per
// cycle: the item is registered at the head of the chain, passes through every cell and
// is then registered as the result; the length of the chain sets how long this takes.
// Clear, unused function codes and requests rejected for a full list or a bad index do not
// enter the chain, and their result is offered in the cycle after acceptance. A stall on
// the result side holds the result until it is taken. One item is worked on at a time, and
// the next item can be accepted in the cycle after the result is taken. Entries read as
// undefined until they are written; only entries below the count are ever read.
module indexed_list_with_search_top #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [3:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [3:0]         rsp_found_index,
   output logic [4:0]         rsp_used_count,
   output logic               rsp_is_empty
);

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > ilws_pkg::POS_W) ? CW : ilws_pkg::POS_W;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BUSY = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   ilws_pkg::token_ctl_type     launch_ff, launch_in;
   logic [ilws_pkg::DATA_W-1:0] key_ff, key_in;
   logic [CW-1:0]               target_ff, target_in;
   logic [1:0]                  status_ff, status_in;
   logic [ilws_pkg::DATA_W-1:0] read_ff, read_in;
   logic [3:0]                  fidx_ff, fidx_in;
   logic [4:0]                  ucount_ff, ucount_in;
   logic                        empty_ff, empty_in;

   ilws_pkg::token_ctl_type     ctl_chain   [0:CAPACITY];
   logic [ilws_pkg::DATA_W-1:0] key_chain   [0:CAPACITY];
   logic [ilws_pkg::DATA_W-1:0] rdata_chain [0:CAPACITY];
   logic [CW-1:0]               hidx_chain  [0:CAPACITY];

   logic req_accept;
   logic pos_ok;
   logic not_full;
   logic immediate;
   logic [1:0] imm_status;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign pos_ok     = (CMP_W'(req_position) < CMP_W'(count_ff));
   assign not_full   = (count_ff < CAP_COUNT);

   assign ctl_chain[0]   = launch_ff;
   assign key_chain[0]   = key_ff;
   assign rdata_chain[0] = '0;
   assign hidx_chain[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ilws_cell #(
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl_in    (ctl_chain[i]),
         .key_in    (key_chain[i]),
         .rdata_in  (rdata_chain[i]),
         .hidx_in   (hidx_chain[i]),
         .target    (target_ff),
         .limit     (count_ff),
         .ctl_out   (ctl_chain[i+1]),
         .key_out   (key_chain[i+1]),
         .rdata_out (rdata_chain[i+1]),
         .hidx_out  (hidx_chain[i+1])
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      launch_in  = '0;
      key_in     = key_ff;
      target_in  = target_ff;
      status_in  = status_ff;
      read_in    = read_ff;
      fidx_in    = fidx_ff;
      ucount_in  = ucount_ff;
      empty_in   = empty_ff;
      immediate  = 1'b0;
      imm_status = ilws_pkg::STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in         = req_value;
               launch_in.func = req_func;
               unique case (req_func) inside
                  ilws_pkg::FUNC_APPEND: begin
                     if (not_full) begin
                        launch_in.valid = 1'b1;
                        target_in       = count_ff;
                        count_in        = count_ff + CW'(1);
                     end else begin
                        immediate  = 1'b1;
                        imm_status = ilws_pkg::STATUS_FULL;
                     end
                  end
                  ilws_pkg::FUNC_CLEAR: begin
                     immediate = 1'b1;
                     count_in  = '0;
                  end
                  ilws_pkg::FUNC_GET, ilws_pkg::FUNC_SET: begin
                     if (pos_ok) begin
                        launch_in.valid = 1'b1;
                        target_in       = CW'(req_position);
                     end else begin
                        immediate  = 1'b1;
                        imm_status = ilws_pkg::STATUS_RANGE;
                     end
                  end
                  ilws_pkg::FUNC_FIND: begin
                     launch_in.valid = 1'b1;
                  end
                  default: begin
                     immediate = 1'b1;
                  end
               endcase
               if (immediate) begin
                  state_in  = ST_RESP;
                  status_in = imm_status;
                  read_in   = '0;
                  fidx_in   = '0;
                  ucount_in = 5'(count_in);
                  empty_in  = (count_in == '0);
               end else begin
                  state_in = ST_BUSY;
               end
            end
         end
         ST_BUSY: begin
            if (ctl_chain[CAPACITY].valid) begin
               state_in = ST_RESP;
               if ((ctl_chain[CAPACITY].func == ilws_pkg::FUNC_FIND)
                   && !ctl_chain[CAPACITY].done) begin
                  status_in = ilws_pkg::STATUS_NOTFOUND;
               end else begin
                  status_in = ilws_pkg::STATUS_OK;
               end
               read_in   = rdata_chain[CAPACITY];
               fidx_in   = 4'(hidx_chain[CAPACITY]);
               ucount_in = 5'(count_ff);
               empty_in  = (count_ff == '0);
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         launch_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         launch_ff <= launch_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      target_ff <= target_in;
      status_ff <= status_in;
      read_ff   <= read_in;
      fidx_ff   <= fidx_in;
      ucount_ff <= ucount_in;
      empty_ff  <= empty_in;
   end

   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_status      = status_ff;
   assign rsp_read_value  = read_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_used_count  = ucount_ff;
   assign rsp_is_empty    = empty_ff;

endmodule

// ===== rtl/core/ilws_checker.sv =====
// Port-level checker for the list top level and the bind that attaches it.
`timescale 1ns / 1ps

module ilws_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_read_value,
   input logic [3:0]         rsp_found_index,
   input logic [4:0]         rsp_used_count,
   input logic               rsp_is_empty
);

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_used_count == 5'd0)))
      else $error("Empty flag disagrees with the used count.");

   a_error_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ilws_pkg::STATUS_OK))
      |-> ((rsp_read_value == 32'sd0) && (rsp_found_index == 4'd0)))
      else $error("An error item carries nonzero data fields.");

   a_one_item : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("More than one item was delivered for one request.");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_used_count)))
      else $error("A stalled item changed.");

   a_input_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("The input was open while a result item was waiting.");

endmodule

bind indexed_list_with_search_top ilws_checker u_ilws_checker (.*);
